>>> hdl/sdspi_pkg.sv
// Shared types and constants for the SD card SPI host sequencer.
`timescale 1ns / 1ps
`default_nettype none
package sdspi_pkg;

  typedef enum logic [26:0] {
    PH_IDLE     = 27'h0000001,
    PH_FILL     = 27'h0000002,
    PH_CMD0     = 27'h0000004,
    PH_CMD8     = 27'h0000008,
    PH_R7       = 27'h0000010,
    PH_V2_55    = 27'h0000020,
    PH_V2_41    = 27'h0000040,
    PH_CMD58    = 27'h0000080,
    PH_OCR      = 27'h0000100,
    PH_V1_55    = 27'h0000200,
    PH_V1_PROBE = 27'h0000400,
    PH_V1L_55   = 27'h0000800,
    PH_V1L_41   = 27'h0001000,
    PH_CMD1     = 27'h0002000,
    PH_CMD16    = 27'h0004000,
    PH_FINAL    = 27'h0008000,
    PH_RD_CMD   = 27'h0010000,
    PH_RD_TOK   = 27'h0020000,
    PH_RD_DATA  = 27'h0040000,
    PH_RD_CRC   = 27'h0080000,
    PH_WR_CMD   = 27'h0100000,
    PH_WR_READY = 27'h0200000,
    PH_WR_TOK   = 27'h0400000,
    PH_WR_DATA  = 27'h0800000,
    PH_WR_CRC   = 27'h1000000,
    PH_WR_RESP  = 27'h2000000,
    PH_WR_BUSY  = 27'h4000000
  } phase_t;

  typedef enum logic [4:0] {
    ENG_OFF  = 5'b00001,
    ENG_PRE  = 5'b00010,
    ENG_WAIT = 5'b00100,
    ENG_SEND = 5'b01000,
    ENG_POLL = 5'b10000
  } eng_t;

  localparam logic [1:0] OP_SLOT  = 2'd0;
  localparam logic [1:0] OP_INIT  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_CMD0     = 4'd1;
  localparam logic [3:0] ST_V2ACMD41 = 4'd2;
  localparam logic [3:0] ST_V1ACMD41 = 4'd3;
  localparam logic [3:0] ST_CMD1     = 4'd4;
  localparam logic [3:0] ST_CMD16    = 4'd5;
  localparam logic [3:0] ST_RDCMD    = 4'd6;
  localparam logic [3:0] ST_WRCMD    = 4'd7;
  localparam logic [3:0] ST_WRREJ    = 4'd8;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_MMC  = 3'd1;
  localparam logic [2:0] KIND_SD1  = 3'd2;
  localparam logic [2:0] KIND_SD2  = 3'd3;
  localparam logic [2:0] KIND_SDHC = 3'd4;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       cs_level;
    logic       slow_clock;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       wr_take;
    logic       done_res;
    logic [3:0] status;
    logic [2:0] card_kind;
    logic       block_addressing;
    logic [7:0] card_response;
    logic       busy_res;
  } result_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] sector_addr;
    logic [7:0]  rx_byte;
    logic [7:0]  wr_data;
  } item_t;

endpackage
`default_nettype wire

>>> hdl/sd_card_spi_host_sequencer.sv
// Top level of the SD card SPI host sequencer: input register, core, output register.
//
// channel  dir  fields (low bit up)
// s_axis   in   tdata: opcode, sector_addr, rx_byte, wr_data
// m_axis   out  tdata: tx_byte..busy_res as listed at the port
// cfg      in   retry_limit
//
// A word accepted on s_axis passes through the input register, then the output register, to m_axis;
// a new word is taken every cycle while the output stage can drain.
// The core updates state as it computes a result from the input register.
// rst clears all control state; retry_limit returns to 200.
// A stalled m_axis holds its word and the input register, and s_axis stalls.
`timescale 1ns / 1ps
`default_nettype none
module sd_card_spi_host_sequencer (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire [7:0]  cfg_wdata,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [55:0] s_axis_tdata,  // opcode, sector_addr, rx_byte, wr_data, zero pad
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [39:0] m_axis_tdata  // tx_byte, cs_level, slow_clock, rd_data, rd_valid,
                                    // wr_take, done_res, status, card_kind,
                                    // block_addressing, card_response, busy_res, pad
);

  logic [7:0] retry_limit;
  logic in_valid, step;
  sdspi_pkg::item_t in_item;
  sdspi_pkg::result_t res;

  assign step = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) retry_limit <= 8'd200;
    else if (cfg_we) retry_limit <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else if (s_axis_tready) in_valid <= s_axis_tvalid;
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.opcode <= s_axis_tdata[1:0];
      in_item.sector_addr <= s_axis_tdata[33:2];
      in_item.rx_byte <= s_axis_tdata[41:34];
      in_item.wr_data <= s_axis_tdata[49:42];
    end
  end

  sdspi_core u_core (
    .clk(clk), .rst(rst), .retry_limit(retry_limit),
    .step(step), .item(in_item), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (step) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata <= {2'd0, res.busy_res, res.card_response, res.block_addressing,
                       res.card_kind, res.status, res.done_res, res.wr_take,
                       res.rd_valid, res.rd_data, res.slow_clock, res.cs_level,
                       res.tx_byte};
    end
  end

endmodule
`default_nettype wire

>>> hdl/sdspi_core.sv
// Sequencer state and per-byte next-state logic.
`timescale 1ns / 1ps
`default_nettype none
module sdspi_core (
  input  wire                  clk,
  input  wire                  rst,
  input  wire [7:0]            retry_limit,
  input  wire                  step,
  input  wire sdspi_pkg::item_t item,
  output sdspi_pkg::result_t   res
);

  sdspi_pkg::phase_t phase, phase_next;
  sdspi_pkg::eng_t   eng, eng_next;
  logic [2:0]  cmd_byte_index, cmd_byte_index_next;
  logic [7:0]  retry_count, retry_count_next;
  logic [7:0]  poll_count, poll_count_next;
  logic [9:0]  data_count, data_count_next;
  logic [7:0]  resp_bytes [4];
  logic [7:0]  resp_bytes_next [4];
  logic [2:0]  kind_reg, kind_reg_next;
  logic        block_mode, block_mode_next;
  logic [31:0] addr_latch, addr_latch_next;
  logic        init_mode, init_mode_next;
  logic [7:0]  last_r1, last_r1_next;
  logic [7:0]  cmd_buf [6];
  logic [7:0]  cmd_buf_next [6];

  logic [7:0] o_tx, o_rdd, lim;
  logic       o_cs, o_rdv, o_take, o_done;
  logic [3:0] o_status;
  logic [7:0] rx;
  logic [7:0] rc_inc, pc_inc;
  logic       att_out, poll_end;
  logic [2:0] idx_inc;
  logic [9:0] dc_inc;
  logic [7:0] r7_2, r7_3, ocr_0;
  logic [31:0] new_addr;

  always_comb begin
    lim = (retry_limit == 8'd0) ? 8'd1 : retry_limit;
    rx = item.rx_byte;
    rc_inc = (retry_count == 8'hFF) ? retry_count : retry_count + 8'd1;
    att_out = rc_inc >= lim;
    pc_inc = (poll_count == 8'hFF) ? poll_count : poll_count + 8'd1;
    poll_end = (rx != 8'hFF) || (pc_inc >= lim);
    idx_inc = cmd_byte_index + 3'd1;
    dc_inc = data_count + 10'd1;
    r7_2 = (data_count[1:0] == 2'd2) ? rx : resp_bytes[2];
    r7_3 = (data_count[1:0] == 2'd3) ? rx : resp_bytes[3];
    ocr_0 = (data_count[1:0] == 2'd0) ? rx : resp_bytes[0];
    new_addr = block_mode ? item.sector_addr : {item.sector_addr[22:0], 9'd0};

    phase_next = phase;
    eng_next = eng;
    cmd_byte_index_next = cmd_byte_index;
    retry_count_next = retry_count;
    poll_count_next = poll_count;
    data_count_next = data_count;
    resp_bytes_next = resp_bytes;
    kind_reg_next = kind_reg;
    block_mode_next = block_mode;
    addr_latch_next = addr_latch;
    init_mode_next = init_mode;
    last_r1_next = last_r1;
    cmd_buf_next = cmd_buf;
    o_tx = 8'hFF; o_cs = 1'b1; o_rdd = 8'd0; o_rdv = 1'b0;
    o_take = 1'b0; o_done = 1'b0; o_status = sdspi_pkg::ST_OK;

    // each "issue" loads the buffer and arms the engine
    if (phase == sdspi_pkg::PH_IDLE) begin
      if (item.opcode == sdspi_pkg::OP_INIT) begin
        init_mode_next = 1'b1; kind_reg_next = sdspi_pkg::KIND_NONE;
        block_mode_next = 1'b0; phase_next = sdspi_pkg::PH_FILL;
        data_count_next = 10'd0;
      end else if (item.opcode == sdspi_pkg::OP_READ ||
                   item.opcode == sdspi_pkg::OP_WRITE) begin
        addr_latch_next = new_addr;
        retry_count_next = 8'd0;
        eng_next = sdspi_pkg::ENG_PRE; cmd_byte_index_next = 3'd0;
        cmd_buf_next[1] = new_addr[31:24]; cmd_buf_next[2] = new_addr[23:16];
        cmd_buf_next[3] = new_addr[15:8];  cmd_buf_next[4] = new_addr[7:0];
        if (item.opcode == sdspi_pkg::OP_READ) begin
          phase_next = sdspi_pkg::PH_RD_CMD;
          cmd_buf_next[0] = 8'h51; cmd_buf_next[5] = 8'h01;
        end else begin
          phase_next = sdspi_pkg::PH_WR_CMD;
          cmd_buf_next[0] = 8'h58; cmd_buf_next[5] = 8'hFF;
        end
      end
    end else if (eng != sdspi_pkg::ENG_OFF) begin
      unique case (eng)
        sdspi_pkg::ENG_PRE: begin
          eng_next = sdspi_pkg::ENG_WAIT; o_cs = 1'b0;
        end
        sdspi_pkg::ENG_WAIT: begin
          o_cs = 1'b0;
          if (rx == 8'hFF) begin
            eng_next = sdspi_pkg::ENG_SEND; cmd_byte_index_next = 3'd0;
            o_tx = cmd_buf[0];
          end
        end
        sdspi_pkg::ENG_SEND: begin
          cmd_byte_index_next = idx_inc; o_cs = 1'b0;
          if (idx_inc < 3'd6) o_tx = cmd_buf[idx_inc];
          else begin
            eng_next = sdspi_pkg::ENG_POLL; poll_count_next = 8'd0;
          end
        end
        default: begin
          poll_count_next = pc_inc;
          if (!poll_end) o_cs = 1'b0;
          else begin
            eng_next = sdspi_pkg::ENG_OFF;
            last_r1_next = rx;
            // response handling; issue() arms engine with a new command
            unique case (phase)
              sdspi_pkg::PH_CMD0: begin
                retry_count_next = rc_inc;
                if (att_out) begin
                  o_done = 1'b1; o_status = sdspi_pkg::ST_CMD0;
                end else if (rx == 8'h01) begin
                  phase_next = sdspi_pkg::PH_CMD8; eng_next = sdspi_pkg::ENG_PRE;
                end else eng_next = sdspi_pkg::ENG_PRE;
              end
              sdspi_pkg::PH_CMD8: begin
                if (rx == 8'h01) begin
                  phase_next = sdspi_pkg::PH_R7; data_count_next = 10'd0; o_cs = 1'b0;
                end else begin
                  phase_next = sdspi_pkg::PH_V1_55; eng_next = sdspi_pkg::ENG_PRE;
                end
              end
              sdspi_pkg::PH_V2_55: begin
                phase_next = sdspi_pkg::PH_V2_41; eng_next = sdspi_pkg::ENG_PRE;
              end
              sdspi_pkg::PH_V2_41: begin
                retry_count_next = rc_inc;
                if (att_out) begin
                  o_done = 1'b1; o_status = sdspi_pkg::ST_V2ACMD41;
                end else if (rx == 8'h00) begin
                  phase_next = sdspi_pkg::PH_CMD58; eng_next = sdspi_pkg::ENG_PRE;
                end else begin
                  phase_next = sdspi_pkg::PH_V2_55; eng_next = sdspi_pkg::ENG_PRE;
                end
              end
              sdspi_pkg::PH_CMD58: begin
                if (rx == 8'h00) begin
                  phase_next = sdspi_pkg::PH_OCR; data_count_next = 10'd0; o_cs = 1'b0;
                end else begin
                  phase_next = sdspi_pkg::PH_CMD16; eng_next = sdspi_pkg::ENG_PRE;
                end
              end
              sdspi_pkg::PH_V1_55: begin
                phase_next = sdspi_pkg::PH_V1_PROBE; eng_next = sdspi_pkg::ENG_PRE;
              end
              sdspi_pkg::PH_V1_PROBE: begin
                retry_count_next = 8'd0; eng_next = sdspi_pkg::ENG_PRE;
                if (rx <= 8'd1) begin
                  kind_reg_next = sdspi_pkg::KIND_SD1;
                  phase_next = sdspi_pkg::PH_V1L_55;
                end else begin
                  kind_reg_next = sdspi_pkg::KIND_MMC;
                  phase_next = sdspi_pkg::PH_CMD1;
                end
              end
              sdspi_pkg::PH_V1L_55: begin
                phase_next = sdspi_pkg::PH_V1L_41; eng_next = sdspi_pkg::ENG_PRE;
              end
              sdspi_pkg::PH_V1L_41: begin
                retry_count_next = rc_inc;
                if (att_out) begin
                  o_done = 1'b1; o_status = sdspi_pkg::ST_V1ACMD41;
                end else if (rx == 8'h00) begin
                  phase_next = sdspi_pkg::PH_CMD16; eng_next = sdspi_pkg::ENG_PRE;
                end else begin
                  phase_next = sdspi_pkg::PH_V1L_55; eng_next = sdspi_pkg::ENG_PRE;
                end
              end
              sdspi_pkg::PH_CMD1: begin
                retry_count_next = rc_inc;
                if (att_out) begin
                  o_done = 1'b1; o_status = sdspi_pkg::ST_CMD1;
                end else if (rx == 8'h00) begin
                  phase_next = sdspi_pkg::PH_CMD16; eng_next = sdspi_pkg::ENG_PRE;
                end else eng_next = sdspi_pkg::ENG_PRE;
              end
              sdspi_pkg::PH_CMD16: begin
                if (rx != 8'h00) begin
                  kind_reg_next = sdspi_pkg::KIND_NONE;
                  o_done = 1'b1; o_status = sdspi_pkg::ST_CMD16;
                end else phase_next = sdspi_pkg::PH_FINAL;
              end
              sdspi_pkg::PH_RD_CMD: begin
                retry_count_next = rc_inc;
                if (att_out) begin
                  o_done = 1'b1; o_status = sdspi_pkg::ST_RDCMD;
                end else if (rx == 8'h00) begin
                  phase_next = sdspi_pkg::PH_RD_TOK; o_cs = 1'b0;
                end else eng_next = sdspi_pkg::ENG_PRE;
              end
              sdspi_pkg::PH_WR_CMD: begin
                retry_count_next = rc_inc;
                if (att_out) begin
                  o_done = 1'b1; o_status = sdspi_pkg::ST_WRCMD;
                end else if (rx == 8'h00) begin
                  phase_next = sdspi_pkg::PH_WR_READY; o_cs = 1'b0;
                end else eng_next = sdspi_pkg::ENG_PRE;
              end
              default: o_done = 1'b1;
            endcase
            if (o_done) phase_next = sdspi_pkg::PH_IDLE;
          end
        end
      endcase
    end else begin
      unique case (phase)
        sdspi_pkg::PH_FILL: begin
          data_count_next = dc_inc;
          if (dc_inc >= 10'd15) begin
            retry_count_next = 8'd0; phase_next = sdspi_pkg::PH_CMD0;
            eng_next = sdspi_pkg::ENG_PRE;
          end
        end
        sdspi_pkg::PH_R7: begin
          resp_bytes_next[data_count[1:0]] = rx;
          data_count_next = dc_inc;
          if (dc_inc < 10'd4) o_cs = 1'b0;
          else if (r7_2 == 8'h01 && r7_3 == 8'hAA) begin
            retry_count_next = 8'd0; phase_next = sdspi_pkg::PH_V2_55;
            eng_next = sdspi_pkg::ENG_PRE;
          end else begin
            phase_next = sdspi_pkg::PH_CMD16; eng_next = sdspi_pkg::ENG_PRE;
          end
        end
        sdspi_pkg::PH_OCR: begin
          resp_bytes_next[data_count[1:0]] = rx;
          data_count_next = dc_inc;
          if (dc_inc < 10'd4) o_cs = 1'b0;
          else begin
            if (ocr_0[6]) begin
              kind_reg_next = sdspi_pkg::KIND_SDHC; block_mode_next = 1'b1;
            end else kind_reg_next = sdspi_pkg::KIND_SD2;
            phase_next = sdspi_pkg::PH_CMD16; eng_next = sdspi_pkg::ENG_PRE;
          end
        end
        sdspi_pkg::PH_RD_TOK: begin
          o_cs = 1'b0;
          if (rx == 8'hFE) begin
            phase_next = sdspi_pkg::PH_RD_DATA; data_count_next = 10'd0;
          end
        end
        sdspi_pkg::PH_RD_DATA: begin
          o_cs = 1'b0; o_rdd = rx; o_rdv = 1'b1;
          data_count_next = dc_inc;
          if (dc_inc == 10'd0 || data_count == 10'd511) begin
            phase_next = sdspi_pkg::PH_RD_CRC; data_count_next = 10'd0;
          end
        end
        sdspi_pkg::PH_RD_CRC: begin
          data_count_next = dc_inc;
          if (dc_inc < 10'd2) o_cs = 1'b0;
          else phase_next = sdspi_pkg::PH_FINAL;
        end
        sdspi_pkg::PH_WR_READY: begin
          o_cs = 1'b0;
          if (rx == 8'hFF) begin
            phase_next = sdspi_pkg::PH_WR_TOK; o_tx = 8'hFE;
          end
        end
        sdspi_pkg::PH_WR_TOK: begin
          phase_next = sdspi_pkg::PH_WR_DATA; data_count_next = 10'd0;
          o_cs = 1'b0; o_tx = item.wr_data; o_take = 1'b1;
        end
        sdspi_pkg::PH_WR_DATA: begin
          data_count_next = dc_inc; o_cs = 1'b0;
          if (data_count != 10'd511 && dc_inc != 10'd0) begin
            o_tx = item.wr_data; o_take = 1'b1;
          end else begin
            phase_next = sdspi_pkg::PH_WR_CRC; data_count_next = 10'd0;
          end
        end
        sdspi_pkg::PH_WR_CRC: begin
          data_count_next = dc_inc; o_cs = 1'b0;
          if (dc_inc >= 10'd2) phase_next = sdspi_pkg::PH_WR_RESP;
        end
        sdspi_pkg::PH_WR_RESP: begin
          if ((rx & 8'h1F) != 8'h05) begin
            o_done = 1'b1; o_status = sdspi_pkg::ST_WRREJ;
            phase_next = sdspi_pkg::PH_IDLE;
          end else begin
            phase_next = sdspi_pkg::PH_WR_BUSY; o_cs = 1'b0;
          end
        end
        sdspi_pkg::PH_WR_BUSY: begin
          o_cs = 1'b0;
          if (rx == 8'hFF) begin
            phase_next = sdspi_pkg::PH_FINAL; o_cs = 1'b1;
          end
        end
        sdspi_pkg::PH_FINAL: begin
          init_mode_next = 1'b0; o_done = 1'b1; phase_next = sdspi_pkg::PH_IDLE;
        end
        default: begin
          o_done = 1'b1; phase_next = sdspi_pkg::PH_IDLE;
        end
      endcase
    end

    // fixed command images for the init phases
    if (eng_next == sdspi_pkg::ENG_PRE && phase_next != sdspi_pkg::PH_RD_CMD &&
        phase_next != sdspi_pkg::PH_WR_CMD) begin
      cmd_byte_index_next = 3'd0;
      cmd_buf_next[1] = 8'h00; cmd_buf_next[2] = 8'h00;
      cmd_buf_next[3] = 8'h00; cmd_buf_next[4] = 8'h00;
      cmd_buf_next[5] = 8'h01;
      unique case (phase_next)
        sdspi_pkg::PH_CMD0: begin
          cmd_buf_next[0] = 8'h40; cmd_buf_next[5] = 8'h95;
        end
        sdspi_pkg::PH_CMD8: begin
          cmd_buf_next[0] = 8'h48; cmd_buf_next[3] = 8'h01;
          cmd_buf_next[4] = 8'hAA; cmd_buf_next[5] = 8'h87;
        end
        sdspi_pkg::PH_V2_41: begin
          cmd_buf_next[0] = 8'h69; cmd_buf_next[1] = 8'h40;
        end
        sdspi_pkg::PH_CMD58: cmd_buf_next[0] = 8'h7A;
        sdspi_pkg::PH_V1_PROBE, sdspi_pkg::PH_V1L_41: cmd_buf_next[0] = 8'h69;
        sdspi_pkg::PH_CMD1: cmd_buf_next[0] = 8'h41;
        sdspi_pkg::PH_CMD16: begin
          cmd_buf_next[0] = 8'h50; cmd_buf_next[3] = 8'h02;
        end
        default: cmd_buf_next[0] = 8'h77;
      endcase
    end
    if (o_done) eng_next = sdspi_pkg::ENG_OFF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sdspi_pkg::PH_IDLE;
      eng <= sdspi_pkg::ENG_OFF;
      cmd_byte_index <= 3'd0;
      retry_count <= 8'd0;
      poll_count <= 8'd0;
      data_count <= 10'd0;
      kind_reg <= sdspi_pkg::KIND_NONE;
      block_mode <= 1'b0;
      addr_latch <= 32'd0;
      init_mode <= 1'b0;
      last_r1 <= 8'hFF;
    end else if (step) begin
      phase <= phase_next;
      eng <= eng_next;
      cmd_byte_index <= cmd_byte_index_next;
      retry_count <= retry_count_next;
      poll_count <= poll_count_next;
      data_count <= data_count_next;
      kind_reg <= kind_reg_next;
      block_mode <= block_mode_next;
      addr_latch <= addr_latch_next;
      init_mode <= init_mode_next;
      last_r1 <= last_r1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      resp_bytes <= resp_bytes_next;
      cmd_buf <= cmd_buf_next;
    end
  end

  always_comb begin
    res.tx_byte = o_tx;
    res.cs_level = o_cs;
    res.slow_clock = init_mode_next;
    res.rd_data = o_rdd;
    res.rd_valid = o_rdv;
    res.wr_take = o_take;
    res.done_res = o_done;
    res.status = o_status;
    res.card_kind = kind_reg_next;
    res.block_addressing = block_mode_next;
    res.card_response = last_r1_next;
    res.busy_res = (phase_next != sdspi_pkg::PH_IDLE);
  end

endmodule
`default_nettype wire

>>> hdl/sdspi_checker.sv
// Port-level assertions for the SD card SPI host sequencer.
`timescale 1ns / 1ps
`default_nettype none
module sdspi_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [39:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed under stall");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[20] |-> !m_axis_tdata[37])
    else $error("done while still busy");
  a_idle_cs: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[37] |-> m_axis_tdata[8] && m_axis_tdata[7:0] == 8'hFF)
    else $error("idle word drives card");
  a_rd_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[18] && m_axis_tdata[19]))
    else $error("read and write data in one word");

endmodule

bind sd_card_spi_host_sequencer sdspi_checker u_chk (
  .clk(clk), .rst(rst), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
